// ===== hdl/bounded_ordered_list_engine_unit_macros.svh =====
// Assertion macros for the bounded ordered list engine.
// Included by RTL files that check their own logic; no other dependencies.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define BOLE_ASSERT_ALWAYS(LBL, CLK_SIG, RST_SIG, COND, MSG) \
  LBL: assert property (@(posedge CLK_SIG) disable iff (RST_SIG) (COND)) else $error(MSG);
// A consequence that must hold in the cycle after its trigger.
`define BOLE_ASSERT_NEXT(LBL, CLK_SIG, RST_SIG, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK_SIG) disable iff (RST_SIG) (ANTE) |=> (CONS)) \
    else $error(MSG);
`else
`define BOLE_ASSERT_ALWAYS(LBL, CLK_SIG, RST_SIG, COND, MSG)
`define BOLE_ASSERT_NEXT(LBL, CLK_SIG, RST_SIG, ANTE, CONS, MSG)
`endif
`endif

// ===== hdl/bole_pkg.sv =====
// Shared types and codes for the bounded ordered list engine.
// No dependencies; used by every module of the block.
package bole_pkg;

  localparam int DATA_W = 32;
  localparam int LEN_W  = 5;

  typedef enum logic [1:0] {
    REQ_INS_FRONT = 2'd0,
    REQ_INS_BACK  = 2'd1,
    REQ_REMOVE    = 2'd2,
    REQ_REVERSE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REVERSE
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_APPEND,
    OP_SHIFT_DOWN,
    OP_ROTATE,
    OP_REV_STEP,
    OP_REV_LAST
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [DATA_W-1:0]  data;
  } cell_ctrl_t;

endpackage

// ===== hdl/bole_cell.sv =====
// One storage cell of the list chain: a list entry plus a spare stack entry.
// Depends on bole_pkg for the cell command struct.
module bole_cell import bole_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  input  logic [DATA_W-1:0] head_val,
  input  logic [DATA_W-1:0] stack_in,
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] stack_val
);

  logic is_slot;
  logic is_tail;

  // The slot just past the last entry, and the last entry itself.
  assign is_slot = (count == CW'(IDX));
  assign is_tail = (count == CW'(IDX + 1));

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_PUSH_FRONT: val <= left_val;
      OP_APPEND: begin
        if (is_slot) begin
          val <= ctrl.data;
        end
      end
      OP_SHIFT_DOWN: val <= right_val;
      OP_ROTATE:     val <= is_tail ? head_val : right_val;
      OP_REV_STEP: begin
        val       <= right_val;
        stack_val <= stack_in;
      end
      OP_REV_LAST:   val <= stack_in;
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/bole_ctrl.sv =====
// Sequencer of the list engine: entry count, command decode and cell commands.
// Depends on bole_pkg and on the assertion macro header.
`include "bounded_ordered_list_engine_unit_macros.svh"

module bole_ctrl import bole_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int CW          = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] item_value,
  input  logic [DATA_W-1:0] head_val,
  output logic              busy,
  output logic              done,
  output status_t           result_status,
  output logic [CW-1:0]     count,
  output cell_ctrl_t        cell_ctrl
);

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     steps;
  logic [CW-1:0]     steps_next;
  logic [DATA_W-1:0] target;
  logic [DATA_W-1:0] target_next;
  logic              found;
  logic              found_next;
  status_t           result_status_next;
  logic              done_next;
  req_t              req_in;
  logic              accept;
  logic              is_full;
  logic              hit;

  assign req_in  = req_t'(req_type);
  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign is_full = (count == CW'(MAX_ENTRIES));
  assign hit     = !found && (head_val == target);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_in == REQ_REMOVE && count != '0) begin
            state_next = ST_SCAN;
          end else if (req_in == REQ_REVERSE && count >= CW'(2)) begin
            state_next = ST_REVERSE;
          end
        end
      end
      ST_SCAN: begin
        if (steps == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_REVERSE: begin
        if (steps == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and result registers.
  always_comb begin
    cell_ctrl.op       = OP_HOLD;
    cell_ctrl.data     = item_value;
    count_next         = count;
    steps_next         = steps;
    target_next        = target;
    found_next         = found;
    result_status_next = result_status;
    done_next          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_in)
            REQ_INS_FRONT, REQ_INS_BACK: begin
              done_next = 1'b1;
              if (is_full) begin
                result_status_next = STAT_FULL;
              end else begin
                cell_ctrl.op = (req_in == REQ_INS_FRONT) ? OP_PUSH_FRONT : OP_APPEND;
                count_next = count + CW'(1);
                result_status_next = STAT_OK;
              end
            end
            REQ_REMOVE: begin
              if (count == '0) begin
                done_next = 1'b1;
                result_status_next = STAT_EMPTY;
              end else begin
                target_next = item_value;
                steps_next  = count;
                found_next  = 1'b0;
              end
            end
            REQ_REVERSE: begin
              if (count < CW'(2)) begin
                done_next = 1'b1;
                result_status_next = STAT_OK;
              end else begin
                steps_next = count - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The head entry is either dropped or rotated to the tail.
        cell_ctrl.op = hit ? OP_SHIFT_DOWN : OP_ROTATE;
        if (hit) begin
          count_next = count - CW'(1);
        end
        found_next = found || hit;
        steps_next = steps - CW'(1);
        if (steps == CW'(1)) begin
          done_next = 1'b1;
          result_status_next = (found || hit) ? STAT_OK : STAT_NOT_FOUND;
        end
      end
      ST_REVERSE: begin
        if (steps != '0) begin
          cell_ctrl.op = OP_REV_STEP;
          steps_next   = steps - CW'(1);
        end else begin
          cell_ctrl.op = OP_REV_LAST;
          done_next    = 1'b1;
          result_status_next = STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      steps <= '0;
      found <= 1'b0;
      done  <= 1'b0;
      result_status <= STAT_OK;
    end else begin
      state <= state_next;
      count <= count_next;
      steps <= steps_next;
      found <= found_next;
      done  <= done_next;
      result_status <= result_status_next;
    end
  end

  always_ff @(posedge clk) begin
    target <= target_next;
  end

  `BOLE_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(MAX_ENTRIES), "entry count above capacity")
  `BOLE_ASSERT_ALWAYS(a_done_idle, clk, rst, !done || state == ST_IDLE, "result strobe while still working")
  `BOLE_ASSERT_NEXT(a_full_drop, clk, rst, accept && is_full && (req_in == REQ_INS_FRONT || req_in == REQ_INS_BACK), done && result_status == STAT_FULL && count == $past(count), "insert into full list not dropped")
  `BOLE_ASSERT_NEXT(a_scan_shrink, clk, rst, state == ST_SCAN, count == $past(count) || count == $past(count) - 1'b1, "remove changed the count by more than one")
  `BOLE_ASSERT_NEXT(a_empty_remove, clk, rst, accept && count == '0 && req_in == REQ_REMOVE, done && result_status == STAT_EMPTY, "remove from empty list not reported")

endmodule

// ===== hdl/bounded_ordered_list_engine_unit.sv =====
// Top level of the bounded ordered list engine: sequencer plus a chain of cells.
// Depends on bole_pkg, bole_cell and bole_ctrl.
//
// This block keeps an ordered list of up to MAX_ENTRIES signed 32-bit values
// in a row of cells, the front of the list in cell 0. A transaction is taken
// at a rising edge where start is high and busy is low, and every transaction
// gives exactly one result: done is high for one cycle, and in that cycle
// status, length, front_value and is_empty describe the list after the
// transaction. The receiver cannot stall, so results must be sampled in the
// done cycle. For inserts at the front or back, done follows in the next
// cycle, busy stays low, and a new transaction may be started every cycle.
// A remove keeps busy high while the entries pass one per cycle through
// the single comparator at the head of the chain (each is either dropped
// or rotated to the tail); done follows in the cycle after the last one.
// A reverse of two or more entries pops the entries from the head into the
// spare stack row, and its last step copies the stack back. A full insert,
// a remove on an empty list and a reverse of fewer than two entries answer
// with done in the next cycle. A new transaction may be started in the
// same cycle that done is high. There is no clearing pass: the cell storage
// is left as it is at reset, and only entries below length are ever shown.

module bounded_ordered_list_engine_unit import bole_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                     done,
  output logic [1:0]               status,
  output logic [LEN_W-1:0]         length,
  output logic signed [DATA_W-1:0] front_value,
  output logic                     is_empty
);

  // The count must hold the capacity itself.
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  cell_ctrl_t        cell_ctrl;
  status_t           result_status;
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] cell_val  [MAX_ENTRIES];
  logic [DATA_W-1:0] stack_val [MAX_ENTRIES];

  bole_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CW          (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req_type      (req_type),
    .item_value    (item_value),
    .head_val      (cell_val[0]),
    .busy          (busy),
    .done          (done),
    .result_status (result_status),
    .count         (count),
    .cell_ctrl     (cell_ctrl)
  );

  // Each cell sees its two neighbors, the head entry and the stack entry of
  // the cell before it. Cell 0 takes new front values and feeds the stack.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;
    logic [DATA_W-1:0] stack_in;

    if (i == 0) begin : g_first
      assign left_val = cell_ctrl.data;
      assign stack_in = cell_val[0];
    end else begin : g_inner
      assign left_val = cell_val[i-1];
      assign stack_in = stack_val[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    bole_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .count     (count),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .stack_in  (stack_in),
      .val       (cell_val[i]),
      .stack_val (stack_val[i])
    );
  end

  // Results are read straight from the state registers in the done cycle.
  assign status      = result_status;
  assign length      = LEN_W'(count);
  assign is_empty    = (count == '0);
  assign front_value = (count != '0) ? cell_val[0] : '0;

endmodule
